// ----- hw/rtl/keypad_calculator_entry_top_assert.svh -----
// Assertion macros for the keypad calculator entry block.
// Included by the controller and the datapath; depends on nothing else.
`ifndef KEYPAD_CALCULATOR_ENTRY_TOP_ASSERT_SVH
`define KEYPAD_CALCULATOR_ENTRY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KCE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kce assertion failed");

// Next-cycle implication, disabled during reset.
`define KCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kce assertion failed");

`endif

// ----- hw/rtl/kce_pkg.sv -----
// Package of the keypad calculator entry block: key codes, operator,
// state and command enums, status struct. Depends on nothing.
package kce_pkg;

  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;
  localparam logic [7:0] KEY_PLUS  = 8'h2B;
  localparam logic [7:0] KEY_MINUS = 8'h2D;
  localparam logic [7:0] KEY_MUL   = 8'h2A;
  localparam logic [7:0] KEY_DIV   = 8'h2F;
  localparam logic [7:0] KEY_EQ    = 8'h3D;

  localparam int unsigned FRAC_STEPS = 4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } kce_op_e;

  typedef enum logic [1:0] {
    KC_DIGIT,
    KC_OPER,
    KC_EQUALS,
    KC_OTHER
  } kce_key_class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_DIV,
    ST_FRAC_INIT,
    ST_FRAC,
    ST_DONE
  } kce_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_DIGIT,
    CMD_SET_OP,
    CMD_ALU,
    CMD_MUL_INIT,
    CMD_MUL_STEP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_ZERO,
    CMD_FRAC_INIT,
    CMD_FRAC_STEP,
    CMD_LOAD_OUT
  } kce_cmd_e;

  typedef struct packed {
    logic    phase;
    kce_op_e op;
    logic    b_zero;
    logic    cnt_zero;
    logic    rem_nonzero;
  } kce_status_t;

  function automatic kce_key_class_e key_class(input logic [7:0] key);
    kce_key_class_e c;
    if (key >= KEY_ZERO && key <= KEY_NINE) begin
      c = KC_DIGIT;
    end else if (key == KEY_PLUS || key == KEY_MINUS || key == KEY_MUL || key == KEY_DIV) begin
      c = KC_OPER;
    end else if (key == KEY_EQ) begin
      c = KC_EQUALS;
    end else begin
      c = KC_OTHER;
    end
    return c;
  endfunction

  function automatic kce_op_e op_of_key(input logic [7:0] key);
    kce_op_e o;
    if (key == KEY_MINUS) begin
      o = OP_SUB;
    end else if (key == KEY_MUL) begin
      o = OP_MUL;
    end else if (key == KEY_DIV) begin
      o = OP_DIV;
    end else begin
      o = OP_ADD;
    end
    return o;
  endfunction

endpackage

// ----- hw/rtl/kce_key_if.sv -----
// Key input channel: valid/ready handshake carrying one key word.
// Depends on nothing.
interface kce_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key;
  logic       leave_mode;

  modport source (output valid, key, leave_mode, input ready);
  modport sink   (input valid, key, leave_mode, output ready);
endinterface

// ----- hw/rtl/kce_result_if.sv -----
// Result output channel: valid/ready handshake carrying one result word.
// Depends on nothing.
interface kce_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] answer;
  logic [3:0]  fraction_digit;
  logic        has_fraction;
  logic        divide_error;

  modport source (output valid, answer, fraction_digit, has_fraction, divide_error,
                  input ready);
  modport sink   (input valid, answer, fraction_digit, has_fraction, divide_error,
                  output ready);
endinterface

// ----- hw/rtl/keypad_calculator_entry_top.sv -----
// Top level of the keypad calculator entry block.
// Joins kce_controller and kce_datapath; uses kce_pkg and the channel interfaces.

// Keys arrive one word at a time; a digit, operator, leave request or ignored
// key is taken while the block stays idle, so it is ready for the next key. On
// '=' in the second-operand phase the block stops taking keys while it works
// out the result: add and subtract in a single ALU step, multiply one shift-add
// step a cycle, divide one restoring quotient bit a cycle, then four steps for
// the fraction digit when a remainder is left. The result sits in an output
// register; keys are taken again while it waits, and a further result waits in
// the controller until the register is free.
module keypad_calculator_entry_top import kce_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  kce_key_if.sink     key_i,
  kce_result_if.source result_o
);

  kce_cmd_e    cmd;
  kce_status_t status;

  kce_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (key_i.valid),
    .in_key_i    (key_i.key),
    .in_leave_i  (key_i.leave_mode),
    .in_ready_o  (key_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kce_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .key_i            (key_i.key),
    .status_o         (status),
    .answer_o         (result_o.answer),
    .fraction_digit_o (result_o.fraction_digit),
    .has_fraction_o   (result_o.has_fraction),
    .divide_error_o   (result_o.divide_error)
  );

endmodule

// ----- hw/rtl/kce_datapath.sv -----
// Datapath: operand entry, shift-add multiplier, radix-2 restoring divider,
// fraction digit and result register. Uses kce_pkg and the assertion header.
`include "keypad_calculator_entry_top_assert.svh"

module kce_datapath import kce_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kce_cmd_e    cmd_i,
  input  logic [7:0]  key_i,
  output kce_status_t status_o,
  output logic [31:0] answer_o,
  output logic [3:0]  fraction_digit_o,
  output logic        has_fraction_o,
  output logic        divide_error_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(OPERAND_WIDTH);

  logic          phase_q;
  kce_op_e       op_q;
  logic [W-1:0]  first_q, second_q;
  logic [W-1:0]  acc_q, rem_q;
  logic [3:0]    fx_q, frac_q;
  logic [CW-1:0] cnt_q;
  logic          hasf_q, err_q;
  logic [31:0]   answer_q;
  logic [3:0]    frac_out_q;
  logic          hasf_out_q, err_out_q;

  logic [W-1:0]  first_nxt, second_nxt;
  logic [3:0]    digit;
  logic          bit_in;
  logic [W:0]    trial, trial_diff;
  logic          ge;
  logic [W+3:0]  rem_x10;

  assign digit      = 4'(key_i - KEY_ZERO);
  assign first_nxt  = W'({first_q, 3'b000}) + W'({first_q, 1'b0}) + W'(digit);
  assign second_nxt = W'({second_q, 3'b000}) + W'({second_q, 1'b0}) + W'(digit);

  assign bit_in     = (cmd_i == CMD_FRAC_STEP) ? fx_q[3] : first_q[W-1];
  assign trial      = {rem_q, bit_in};
  assign trial_diff = trial - {1'b0, second_q};
  assign ge         = trial >= {1'b0, second_q};
  assign rem_x10    = {1'b0, rem_q, 3'b000} + {3'b000, rem_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      op_q     <= OP_ADD;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      unique case (cmd_i)
        CMD_CLEAR, CMD_LOAD_OUT: begin
          phase_q  <= 1'b0;
          op_q     <= OP_ADD;
          first_q  <= '0;
          second_q <= '0;
        end
        CMD_DIGIT: begin
          if (phase_q) begin
            second_q <= second_nxt;
          end else begin
            first_q <= first_nxt;
          end
        end
        CMD_SET_OP: begin
          op_q    <= op_of_key(key_i);
          phase_q <= 1'b1;
        end
        CMD_MUL_STEP: begin
          first_q  <= {first_q[W-2:0], 1'b0};
          second_q <= {1'b0, second_q[W-1:1]};
        end
        CMD_DIV_STEP: begin
          first_q <= {first_q[W-2:0], ge};
        end
        CMD_DIV_ZERO: begin
          first_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_ALU: begin
        acc_q  <= (op_q == OP_SUB) ? first_q - second_q : first_q + second_q;
        hasf_q <= 1'b0;
        err_q  <= 1'b0;
        frac_q <= '0;
      end
      CMD_MUL_INIT: begin
        acc_q  <= '0;
        cnt_q  <= CW'(W - 1);
        hasf_q <= 1'b0;
        err_q  <= 1'b0;
        frac_q <= '0;
      end
      CMD_MUL_STEP: begin
        acc_q <= acc_q + (second_q[0] ? first_q : '0);
        cnt_q <= cnt_q - 1'b1;
      end
      CMD_DIV_INIT: begin
        rem_q  <= '0;
        cnt_q  <= CW'(W - 1);
        hasf_q <= 1'b0;
        err_q  <= 1'b0;
        frac_q <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q <= ge ? trial_diff[W-1:0] : trial[W-1:0];
        cnt_q <= cnt_q - 1'b1;
      end
      CMD_DIV_ZERO: begin
        hasf_q <= 1'b0;
        err_q  <= 1'b1;
        frac_q <= '0;
      end
      CMD_FRAC_INIT: begin
        rem_q  <= rem_x10[W+3:4];
        fx_q   <= rem_x10[3:0];
        frac_q <= '0;
        hasf_q <= 1'b1;
        cnt_q  <= CW'(FRAC_STEPS - 1);
      end
      CMD_FRAC_STEP: begin
        rem_q  <= ge ? trial_diff[W-1:0] : trial[W-1:0];
        fx_q   <= {fx_q[2:0], 1'b0};
        frac_q <= {frac_q[2:0], ge};
        cnt_q  <= cnt_q - 1'b1;
      end
      CMD_LOAD_OUT: begin
        answer_q   <= 32'((op_q == OP_DIV) ? first_q : acc_q);
        frac_out_q <= frac_q;
        hasf_out_q <= hasf_q;
        err_out_q  <= err_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.phase       = phase_q;
  assign status_o.op          = op_q;
  assign status_o.b_zero      = (second_q == '0);
  assign status_o.cnt_zero    = (cnt_q == '0);
  assign status_o.rem_nonzero = (rem_q != '0);

  assign answer_o         = answer_q;
  assign fraction_digit_o = frac_out_q;
  assign has_fraction_o   = hasf_out_q;
  assign divide_error_o   = err_out_q;

  `KCE_ASSERT_NEXT(a_rem_below_divisor, clk_i, rst_ni, cmd_i == CMD_DIV_STEP || cmd_i == CMD_FRAC_STEP || cmd_i == CMD_FRAC_INIT, rem_q < second_q)
  `KCE_ASSERT_NEXT(a_load_clears_entry, clk_i, rst_ni, cmd_i == CMD_LOAD_OUT, !phase_q && first_q == '0 && second_q == '0)
  `KCE_ASSERT_NEXT(a_frac_digit_range, clk_i, rst_ni, cmd_i == CMD_LOAD_OUT, fraction_digit_o <= 4'd9)

endmodule

// ----- hw/rtl/kce_controller.sv -----
// Controller: key decode and sequencing of the datapath operations.
// Uses kce_pkg and the assertion header.
`include "keypad_calculator_entry_top_assert.svh"

module kce_controller import kce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_key_i,
  input  logic        in_leave_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  input  kce_status_t status_i,
  output kce_cmd_e    cmd_o
);

  kce_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (in_leave_i) begin
            cmd_o = CMD_CLEAR;
          end else begin
            unique case (key_class(in_key_i))
              KC_DIGIT: cmd_o = CMD_DIGIT;
              KC_OPER: begin
                if (!status_i.phase) cmd_o = CMD_SET_OP;
              end
              KC_EQUALS: begin
                if (status_i.phase) state_d = ST_START;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_START: begin
        unique case (status_i.op)
          OP_ADD, OP_SUB: begin
            cmd_o   = CMD_ALU;
            state_d = ST_DONE;
          end
          OP_MUL: begin
            cmd_o   = CMD_MUL_INIT;
            state_d = ST_MUL;
          end
          OP_DIV: begin
            if (status_i.b_zero) begin
              cmd_o   = CMD_DIV_ZERO;
              state_d = ST_DONE;
            end else begin
              cmd_o   = CMD_DIV_INIT;
              state_d = ST_DIV;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_MUL: begin
        cmd_o = CMD_MUL_STEP;
        if (status_i.cnt_zero) state_d = ST_DONE;
      end
      ST_DIV: begin
        cmd_o = CMD_DIV_STEP;
        if (status_i.cnt_zero) state_d = ST_FRAC_INIT;
      end
      ST_FRAC_INIT: begin
        if (status_i.rem_nonzero) begin
          cmd_o   = CMD_FRAC_INIT;
          state_d = ST_FRAC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FRAC: begin
        cmd_o = CMD_FRAC_STEP;
        if (status_i.cnt_zero) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `KCE_ASSERT_NEXT(a_load_to_idle, clk_i, rst_ni, state_q == ST_DONE && (!out_valid_q || out_ready_i), out_valid_q && state_q == ST_IDLE)
  `KCE_ASSERT_NOW(a_busy_no_entry, clk_i, rst_ni, state_q != ST_IDLE, cmd_o != CMD_DIGIT && cmd_o != CMD_SET_OP && cmd_o != CMD_CLEAR)
  `KCE_ASSERT_NEXT(a_mul_ends, clk_i, rst_ni, state_q == ST_MUL && status_i.cnt_zero, state_q == ST_DONE)

endmodule

// ----- verif/kce_result_checker.sv -----
// Checker for the keypad calculator entry block: watches the key and result channels,
// predicts each result word and compares it field by field.
// Depends on kce_pkg, kce_key_if and kce_result_if.
module kce_result_checker import kce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kce_key_if          key_ch,
  kce_result_if       res_ch,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned div_zero_o,
  output int unsigned fractions_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] answer;
    logic [3:0]  fraction_digit;
    logic        has_fraction;
    logic        divide_error;
  } calc_result_t;

  calc_result_t expected_answers[$];
  calc_result_t got;
  calc_result_t want;

  logic        in_second;
  logic [31:0] lhs;
  logic [31:0] rhs;
  kce_op_e     chosen_op;
  logic [7:0]  k;

  function automatic calc_result_t evaluate(input logic [31:0] a, input logic [31:0] b,
                                            input kce_op_e op);
    calc_result_t r;
    logic [63:0] rem;
    r = '0;
    rem = '0;
    case (op)
      OP_ADD: r.answer = a + b;
      OP_SUB: r.answer = a - b;
      OP_MUL: r.answer = a * b;
      default: begin
        if (b == 32'd0) begin
          r.divide_error = 1'b1;
        end else begin
          r.answer = a / b;
          rem = 64'(a % b);
          if (rem != 64'd0) begin
            r.has_fraction   = 1'b1;
            r.fraction_digit = 4'((rem * 64'd10) / 64'(b));
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_answers.delete();
      in_second   = 1'b0;
      lhs         = '0;
      rhs         = '0;
      chosen_op   = OP_ADD;
      errors_o    = 0;
      pending_o   = 0;
      results_o   = 0;
      div_zero_o  = 0;
      fractions_o = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.answer, res_ch.fraction_digit, res_ch.has_fraction,
                res_ch.divide_error};
        if (expected_answers.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result word: expected none, actual %h", $time, got);
        end else begin
          want = expected_answers.pop_front();
          results_o++;
          if (want.divide_error) div_zero_o++;
          if (want.has_fraction) fractions_o++;
          check_field("answer", want.answer, got.answer);
          check_field("fraction_digit", 32'(want.fraction_digit), 32'(got.fraction_digit));
          check_field("has_fraction", 32'(want.has_fraction), 32'(got.has_fraction));
          check_field("divide_error", 32'(want.divide_error), 32'(got.divide_error));
        end
      end
      if (key_ch.valid && key_ch.ready) begin
        k = key_ch.key;
        if (key_ch.leave_mode) begin
          in_second = 1'b0;
          lhs       = '0;
          rhs       = '0;
          chosen_op = OP_ADD;
        end else if (k >= KEY_ZERO && k <= KEY_NINE) begin
          if (!in_second) lhs = lhs * 10 + 32'(k - KEY_ZERO);
          else            rhs = rhs * 10 + 32'(k - KEY_ZERO);
        end else if (k == KEY_PLUS || k == KEY_MINUS || k == KEY_MUL || k == KEY_DIV) begin
          if (!in_second) begin
            case (k)
              KEY_PLUS:  chosen_op = OP_ADD;
              KEY_MINUS: chosen_op = OP_SUB;
              KEY_MUL:   chosen_op = OP_MUL;
              default:   chosen_op = OP_DIV;
            endcase
            in_second = 1'b1;
          end
        end else if (k == KEY_EQ && in_second) begin
          expected_answers.push_back(evaluate(lhs, rhs, chosen_op));
          in_second = 1'b0;
          lhs       = '0;
          rhs       = '0;
          chosen_op = OP_ADD;
        end
      end
      pending_o = expected_answers.size();
    end
  end

endmodule

// ----- verif/tb_keypad_calculator_entry_top.sv -----
// Testbench top for keypad_calculator_entry_top: drives key words with random gaps and
// result back-pressure, and gives the verdict from kce_result_checker.
// Depends on kce_pkg, the channel interfaces, the block and the checker.
module tb_keypad_calculator_entry_top;
  import kce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TARGET_WORDS = 1450;
  localparam int unsigned QUIET_FROM   = 1300;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst_n;

  kce_key_if    key_ch();
  kce_result_if res_ch();

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned div_zero;
  int unsigned fractions;

  int unsigned words_sent;
  int unsigned noise_sent;
  int unsigned cycles;
  int unsigned stall_left;
  int unsigned entries;
  logic        quiet;
  logic [7:0]  op_keys [4];

  keypad_calculator_entry_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .key_i   (key_ch),
    .result_o(res_ch)
  );

  kce_result_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .key_ch     (key_ch),
    .res_ch     (res_ch),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .div_zero_o (div_zero),
    .fractions_o(fractions)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // hold result ready low in random bursts
  initial begin
    res_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !quiet) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
        stall_left   = 0;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  task automatic send_key(input logic [7:0] k, input logic lv);
    key_ch.valid      = 1'b1;
    key_ch.key        = k;
    key_ch.leave_mode = lv;
    do @(posedge clk); while (!key_ch.ready);
    words_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      key_ch.valid = 1'b0;
      key_ch.key   = 8'($urandom);
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic send_noise();
    noise_sent++;
    send_key(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_number(input int unsigned n_digits);
    for (int unsigned i = 0; i < n_digits; i++) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      send_key(KEY_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end
  endtask

  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0)      return 0;
    else if (sel <= 6) return $urandom_range(1, 3);
    else if (sel <= 8) return $urandom_range(4, 7);
    else               return $urandom_range(8, 14);
  endfunction

  task automatic drain();
    key_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    op_keys           = '{KEY_PLUS, KEY_MINUS, KEY_MUL, KEY_DIV};
    quiet             = 1'b0;
    words_sent        = 0;
    noise_sent        = 0;
    cycles            = 0;
    entries           = 0;
    rst_n             = 1'b0;
    key_ch.valid      = 1'b0;
    key_ch.key        = '0;
    key_ch.leave_mode = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_key(KEY_ZERO + 8'd5, 1'b1);
    send_key(KEY_EQ, 1'b0);
    send_key(8'h00, 1'b0);
    send_key(8'hFF, 1'b0);
    send_key(KEY_ZERO + 8'd7, 1'b0); send_key(KEY_PLUS, 1'b0);
    send_key(KEY_ZERO + 8'd5, 1'b0); send_key(KEY_EQ, 1'b0);
    send_key(KEY_ZERO + 8'd3, 1'b0); send_key(KEY_MINUS, 1'b0); send_key(KEY_MUL, 1'b0);
    send_key(KEY_ZERO + 8'd8, 1'b0); send_key(KEY_EQ, 1'b0);
    send_key(KEY_ZERO + 8'd7, 1'b0); send_key(KEY_DIV, 1'b0);
    send_key(KEY_ZERO, 1'b0);        send_key(KEY_EQ, 1'b0);
    send_key(KEY_ZERO + 8'd7, 1'b0); send_key(KEY_MUL, 1'b0);
    send_key(KEY_ZERO + 8'd9, 1'b0); send_key(KEY_EQ, 1'b0);
    send_key(KEY_ZERO + 8'd2, 1'b0); send_key(KEY_DIV, 1'b0);
    send_key(KEY_ZERO + 8'd3, 1'b0); send_key(KEY_EQ, 1'b0);
    drain();

    while (words_sent - noise_sent < TARGET_WORDS) begin
      if (words_sent - noise_sent >= QUIET_FROM) quiet = 1'b1;
      entries++;
      if (entries == 40) drain();
      send_number(pick_length());
      if ($urandom_range(0, 29) == 0) begin
        noise_sent++;
        send_key(8'($urandom_range(0, 255)), 1'b1);
        continue;
      end
      send_key(op_keys[$urandom_range(0, 3)], 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        noise_sent++;
        send_key(op_keys[$urandom_range(0, 3)], 1'b0);
      end
      send_number(pick_length());
      if ($urandom_range(0, 29) == 0) begin
        noise_sent++;
        send_key(8'($urandom_range(0, 255)), 1'b1);
        continue;
      end
      send_key(KEY_EQ, 1'b0);
    end

    drain();
    repeat (60) @(negedge clk);
    $display("Sent %0d key words (%0d noise, stray or leave) over %0d entries",
             words_sent, noise_sent, entries);
    $display("Checked %0d results: %0d divide-by-zero, %0d with a fraction digit",
             results, div_zero, fractions);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- keypad_calculator_entry_top.f -----
+incdir+hw/rtl
hw/rtl/kce_pkg.sv
hw/rtl/kce_key_if.sv
hw/rtl/kce_result_if.sv
hw/rtl/kce_datapath.sv
hw/rtl/kce_controller.sv
hw/rtl/keypad_calculator_entry_top.sv
verif/kce_result_checker.sv
verif/tb_keypad_calculator_entry_top.sv
